// File: hw/rtl/lzdc_pkg.sv
// Shared types, constants and the CRC-32 byte update for the LZSS decoder.
// No dependencies; used by lzss_decode_crc32_unit.
package lzdc_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);

    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [7:0]  TYPE_ID   = 8'h10;
    localparam logic [3:0]  FLAG_NEED = 4'd8;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BADTYPE = 3'd1;
    localparam logic [2:0] ST_ZEROLEN = 3'd2;
    localparam logic [2:0] ST_TRUNC   = 3'd3;
    localparam logic [2:0] ST_DIST    = 3'd4;
    localparam logic [2:0] ST_RUN     = 3'd5;

    typedef enum logic [2:0] {
        PH_TYPE,
        PH_LEN0,
        PH_LEN1,
        PH_LEN2,
        PH_DATA,
        PH_REFLO,
        PH_SKIP
    } phase_t;

    typedef enum logic {
        CTL_IN,
        CTL_COPY
    } ctl_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'b0, data};
        for (int b = 0; b < 8; b++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/lzdc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read during write to the same address returns the old data. No dependencies.
module lzdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/lzss_decode_crc32_unit.sv
// Streaming type 0x10 LZSS decoder with CRC-32 of the decompressed data.
// Depends on lzdc_pkg and lzdc_ram (history window).
//
// Usage:
//  s_ channel: one compressed byte per request (s_in_byte), s_final_byte marks
//  the last byte of a file. m_ channel: one result per file (m_status,
//  m_crc_value, m_out_size), on completion or on the first error; later bytes
//  of that file are consumed without a result until the final byte.
//  Header, flag and literal bytes are taken one per cycle while s_ready is high.
//  The second byte of a back-reference starts a copy of run bytes (3 to 18),
//  with s_ready low; the copy reads and writes the 4096-byte window once per
//  cycle through its single read port. Distance 1 repeats the last written byte.
//  Latency: the result is presented the cycle after the byte (or the last copy
//  cycle) that causes it.
//  While a result waits on m_ready, bytes are still taken in the skip phase or
//  in the cycle the result leaves; otherwise s_ready stays low.
//  Reset (aresetn low, synchronous) clears the result register and arms the
//  header parse; the window needs no clearing since reads only reach bytes
//  written earlier in the same file.
module lzss_decode_crc32_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_final_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_crc_value,
    output logic [23:0] m_out_size
);

    localparam int AW = lzdc_pkg::WIN_AW;

    lzdc_pkg::phase_t phase_reg, phase_next;
    lzdc_pkg::ctl_t   ctl_reg, ctl_next;

    logic [23:0]   declared_reg, declared_next;
    logic [23:0]   pc_reg, pc_next;
    logic [31:0]   crc_reg, crc_next;
    logic [7:0]    flag_bits_reg, flag_bits_next;
    logic [3:0]    flag_index_reg, flag_index_next;
    logic [7:0]    ref_high_reg, ref_high_next;

    logic [AW-1:0] copy_src_reg, copy_src_next;
    logic [4:0]    left_reg, left_next;
    logic          dist_one_reg, dist_one_next;
    logic          first_reg, first_next;
    logic          last_save_reg, last_save_next;
    logic [7:0]    last_byte_reg, last_byte_next;

    logic          m_valid_reg, m_valid_next;
    logic [2:0]    m_status_reg, m_status_next;
    logic [31:0]   m_crc_reg, m_crc_next;
    logic [23:0]   m_size_reg, m_size_next;

    logic          win_wr_en;
    logic [AW-1:0] win_wr_addr;
    logic [7:0]    win_wr_data;
    logic [AW-1:0] win_rd_addr;
    logic [7:0]    win_rd_data;

    lzdc_ram #(
        .WIDTH (8),
        .DEPTH (lzdc_pkg::WINDOW_DEPTH)
    ) u_window (
        .clk     (aclk),
        .wr_en   (win_wr_en),
        .wr_addr (win_wr_addr),
        .wr_data (win_wr_data),
        .rd_addr (win_rd_addr),
        .rd_data (win_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= lzdc_pkg::PH_TYPE;
            ctl_reg        <= lzdc_pkg::CTL_IN;
            declared_reg   <= '0;
            pc_reg         <= '0;
            crc_reg        <= lzdc_pkg::CRC_INIT;
            flag_bits_reg  <= '0;
            flag_index_reg <= lzdc_pkg::FLAG_NEED;
            ref_high_reg   <= '0;
            left_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            ctl_reg        <= ctl_next;
            declared_reg   <= declared_next;
            pc_reg         <= pc_next;
            crc_reg        <= crc_next;
            flag_bits_reg  <= flag_bits_next;
            flag_index_reg <= flag_index_next;
            ref_high_reg   <= ref_high_next;
            left_reg       <= left_next;
            m_valid_reg    <= m_valid_next;
        end
        copy_src_reg  <= copy_src_next;
        dist_one_reg  <= dist_one_next;
        first_reg     <= first_next;
        last_save_reg <= last_save_next;
        last_byte_reg <= last_byte_next;
        m_status_reg  <= m_status_next;
        m_crc_reg     <= m_crc_next;
        m_size_reg    <= m_size_next;
    end

    always_comb begin
        logic        accept;
        logic        last_v;
        logic        fin;
        logic [2:0]  fin_status;
        logic        restart;
        logic        item_done;
        logic [23:0] len;
        logic [12:0] ref_dist;
        logic [4:0]  run;
        logic [23:0] room;
        logic [23:0] src_full;
        logic [7:0]  copy_byte;

        phase_next      = phase_reg;
        ctl_next        = ctl_reg;
        declared_next   = declared_reg;
        pc_next         = pc_reg;
        crc_next        = crc_reg;
        flag_bits_next  = flag_bits_reg;
        flag_index_next = flag_index_reg;
        ref_high_next   = ref_high_reg;
        copy_src_next   = copy_src_reg;
        left_next       = left_reg;
        dist_one_next   = dist_one_reg;
        first_next      = first_reg;
        last_save_next  = last_save_reg;
        last_byte_next  = last_byte_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_crc_next      = m_crc_reg;
        m_size_next     = m_size_reg;

        win_wr_en   = 1'b0;
        win_wr_addr = pc_reg[AW-1:0];
        win_wr_data = s_in_byte;
        win_rd_addr = copy_src_reg;

        fin        = 1'b0;
        fin_status = lzdc_pkg::ST_OK;
        restart    = 1'b0;
        item_done  = 1'b0;
        last_v     = s_final_byte;

        len       = {s_in_byte, declared_reg[15:0]};
        ref_dist  = {1'b0, ref_high_reg[3:0], s_in_byte} + 13'd1;
        run       = {1'b0, ref_high_reg[7:4]} + 5'd3;
        room      = declared_reg - pc_reg;
        src_full  = pc_reg - {11'b0, ref_dist};
        copy_byte = (dist_one_reg && !first_reg) ? last_byte_reg : win_rd_data;

        s_ready = (ctl_reg == lzdc_pkg::CTL_IN) &&
                  (!m_valid_reg || m_ready || phase_reg == lzdc_pkg::PH_SKIP);
        accept  = s_valid && s_ready;

        case (ctl_reg)
            lzdc_pkg::CTL_IN: begin
                if (accept) begin
                    case (phase_reg)
                        lzdc_pkg::PH_TYPE: begin
                            if (s_in_byte != lzdc_pkg::TYPE_ID) begin
                                fin        = 1'b1;
                                fin_status = lzdc_pkg::ST_BADTYPE;
                            end else begin
                                phase_next = lzdc_pkg::PH_LEN0;
                                fin        = s_final_byte;
                                fin_status = lzdc_pkg::ST_TRUNC;
                            end
                        end
                        lzdc_pkg::PH_LEN0: begin
                            declared_next = {16'b0, s_in_byte};
                            phase_next    = lzdc_pkg::PH_LEN1;
                            fin           = s_final_byte;
                            fin_status    = lzdc_pkg::ST_TRUNC;
                        end
                        lzdc_pkg::PH_LEN1: begin
                            declared_next = {8'b0, s_in_byte, declared_reg[7:0]};
                            phase_next    = lzdc_pkg::PH_LEN2;
                            fin           = s_final_byte;
                            fin_status    = lzdc_pkg::ST_TRUNC;
                        end
                        lzdc_pkg::PH_LEN2: begin
                            declared_next = len;
                            if (len == 24'd0) begin
                                fin        = 1'b1;
                                fin_status = lzdc_pkg::ST_ZEROLEN;
                            end else begin
                                phase_next      = lzdc_pkg::PH_DATA;
                                flag_index_next = lzdc_pkg::FLAG_NEED;
                                fin             = s_final_byte;
                                fin_status      = lzdc_pkg::ST_TRUNC;
                            end
                        end
                        lzdc_pkg::PH_DATA: begin
                            if (flag_index_reg >= lzdc_pkg::FLAG_NEED) begin
                                flag_bits_next  = s_in_byte;
                                flag_index_next = 4'd0;
                                fin             = s_final_byte;
                                fin_status      = lzdc_pkg::ST_TRUNC;
                            end else if (!flag_bits_reg[7]) begin
                                win_wr_en   = 1'b1;
                                win_wr_data = s_in_byte;
                                crc_next    = lzdc_pkg::crc32_byte(crc_reg, s_in_byte);
                                pc_next     = pc_reg + 24'd1;
                                item_done   = 1'b1;
                            end else begin
                                ref_high_next = s_in_byte;
                                phase_next    = lzdc_pkg::PH_REFLO;
                                fin           = s_final_byte;
                                fin_status    = lzdc_pkg::ST_TRUNC;
                            end
                        end
                        lzdc_pkg::PH_REFLO: begin
                            if ({11'b0, ref_dist} > pc_reg) begin
                                fin        = 1'b1;
                                fin_status = lzdc_pkg::ST_DIST;
                            end else if ({19'b0, run} > room) begin
                                fin        = 1'b1;
                                fin_status = lzdc_pkg::ST_RUN;
                            end else begin
                                win_rd_addr    = src_full[AW-1:0];
                                copy_src_next  = src_full[AW-1:0] + AW'(1);
                                left_next      = run - 5'd1;
                                dist_one_next  = (ref_dist == 13'd1);
                                first_next     = 1'b1;
                                last_save_next = s_final_byte;
                                phase_next     = lzdc_pkg::PH_DATA;
                                ctl_next       = lzdc_pkg::CTL_COPY;
                            end
                        end
                        lzdc_pkg::PH_SKIP: begin
                            restart = s_final_byte;
                        end
                        default: begin
                            restart = s_final_byte;
                        end
                    endcase
                end
            end
            lzdc_pkg::CTL_COPY: begin
                last_v         = last_save_reg;
                win_wr_en      = 1'b1;
                win_wr_data    = copy_byte;
                crc_next       = lzdc_pkg::crc32_byte(crc_reg, copy_byte);
                pc_next        = pc_reg + 24'd1;
                last_byte_next = copy_byte;
                first_next     = 1'b0;
                if (left_reg != 5'd0) begin
                    copy_src_next = copy_src_reg + AW'(1);
                    left_next     = left_reg - 5'd1;
                end else begin
                    ctl_next  = lzdc_pkg::CTL_IN;
                    item_done = 1'b1;
                end
            end
            default: begin
                ctl_next = lzdc_pkg::CTL_IN;
            end
        endcase

        if (item_done) begin
            flag_bits_next  = {flag_bits_reg[6:0], 1'b0};
            flag_index_next = flag_index_reg + 4'd1;
            phase_next      = lzdc_pkg::PH_DATA;
            if (pc_next >= declared_reg) begin
                fin        = 1'b1;
                fin_status = lzdc_pkg::ST_OK;
            end else if (last_v) begin
                fin        = 1'b1;
                fin_status = lzdc_pkg::ST_TRUNC;
            end
        end

        if (fin) begin
            m_valid_next  = 1'b1;
            m_status_next = fin_status;
            m_crc_next    = (fin_status == lzdc_pkg::ST_OK) ? ~crc_next : 32'h0;
            m_size_next   = pc_next;
            if (last_v) begin
                restart = 1'b1;
            end else begin
                phase_next = lzdc_pkg::PH_SKIP;
            end
        end

        if (restart) begin
            phase_next      = lzdc_pkg::PH_TYPE;
            declared_next   = '0;
            pc_next         = '0;
            crc_next        = lzdc_pkg::CRC_INIT;
            flag_bits_next  = '0;
            flag_index_next = lzdc_pkg::FLAG_NEED;
            ref_high_next   = '0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_crc_value = m_crc_reg;
    assign m_out_size  = m_size_reg;

endmodule

// File: test/lzss_decode_crc32_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for lzss_decode_crc32_unit: feeds compressed files one byte per
// request and checks every status/CRC/size result against a behavioral decoder.
// Depends on lzdc_pkg and the lzss_decode_crc32_unit RTL.

typedef struct {
    logic [2:0]  status;
    logic [31:0] crc;
    logic [23:0] size;
} file_summary_t;

class lz_file_tracker;
    lzdc_pkg::phase_t phase;
    logic [23:0]    decl_len;
    logic [23:0]    out_count;
    logic [31:0]    crc;
    logic [7:0]     flags;
    logic [3:0]     flag_pos;
    logic [7:0]     ref_hi;
    logic [7:0]     window [lzdc_pkg::WINDOW_DEPTH];
    file_summary_t  summary_q[$];
    int unsigned    live_requests;
    int unsigned    checked;
    int unsigned    errors;

    function new();
        rearm();
        live_requests = 0;
        checked = 0;
        errors = 0;
    endfunction

    function void rearm();
        phase = lzdc_pkg::PH_TYPE;
        decl_len = '0;
        out_count = '0;
        crc = lzdc_pkg::CRC_INIT;
        flags = '0;
        flag_pos = lzdc_pkg::FLAG_NEED;
        ref_hi = '0;
    endfunction

    function void put_byte(logic [7:0] v);
        int k;
        window[out_count % lzdc_pkg::WINDOW_DEPTH] = v;
        crc = crc ^ {24'h0, v};
        for (k = 0; k < 8; k++) begin
            crc = (crc >> 1) ^ (crc[0] ? lzdc_pkg::CRC_POLY : 32'h0);
        end
        out_count = out_count + 1'b1;
    endfunction

    function void close_file(logic [2:0] code, logic last);
        file_summary_t s;
        s.status = code;
        s.crc = (code == lzdc_pkg::ST_OK) ? ~crc : 32'h0;
        s.size = out_count;
        summary_q.push_back(s);
        if (last) begin
            rearm();
        end else begin
            phase = lzdc_pkg::PH_SKIP;
        end
    endfunction

    function void cut_short(logic last);
        if (last) close_file(lzdc_pkg::ST_TRUNC, last);
    endfunction

    function void next_item(logic last);
        flags = flags << 1;
        flag_pos = flag_pos + 1'b1;
        phase = lzdc_pkg::PH_DATA;
        if (out_count >= decl_len) begin
            close_file(lzdc_pkg::ST_OK, last);
        end else begin
            cut_short(last);
        end
    endfunction

    function void note_request(logic [7:0] b, logic last);
        int unsigned ref_dist;
        int unsigned run;
        int unsigned idx;
        int unsigned k;
        live_requests++;
        case (phase)
            lzdc_pkg::PH_TYPE: begin
                if (b != lzdc_pkg::TYPE_ID) begin
                    close_file(lzdc_pkg::ST_BADTYPE, last);
                end else begin
                    phase = lzdc_pkg::PH_LEN0;
                    cut_short(last);
                end
            end
            lzdc_pkg::PH_LEN0: begin
                decl_len = {16'h0, b};
                phase = lzdc_pkg::PH_LEN1;
                cut_short(last);
            end
            lzdc_pkg::PH_LEN1: begin
                decl_len[15:8] = b;
                phase = lzdc_pkg::PH_LEN2;
                cut_short(last);
            end
            lzdc_pkg::PH_LEN2: begin
                decl_len[23:16] = b;
                if (decl_len == 0) begin
                    close_file(lzdc_pkg::ST_ZEROLEN, last);
                end else begin
                    phase = lzdc_pkg::PH_DATA;
                    flag_pos = lzdc_pkg::FLAG_NEED;
                    cut_short(last);
                end
            end
            lzdc_pkg::PH_DATA: begin
                if (flag_pos >= lzdc_pkg::FLAG_NEED) begin
                    flags = b;
                    flag_pos = '0;
                    cut_short(last);
                end else if (!flags[7]) begin
                    put_byte(b);
                    next_item(last);
                end else begin
                    ref_hi = b;
                    phase = lzdc_pkg::PH_REFLO;
                    cut_short(last);
                end
            end
            lzdc_pkg::PH_REFLO: begin
                ref_dist = {ref_hi[3:0], b} + 1;
                run = ref_hi[7:4] + 3;
                if (ref_dist > out_count) begin
                    close_file(lzdc_pkg::ST_DIST, last);
                end else if (run > decl_len - out_count) begin
                    close_file(lzdc_pkg::ST_RUN, last);
                end else begin
                    for (k = 0; k < run; k++) begin
                        idx = (out_count - ref_dist) % lzdc_pkg::WINDOW_DEPTH;
                        put_byte(window[idx]);
                    end
                    next_item(last);
                end
            end
            default: begin
                if (last) rearm();
            end
        endcase
    endfunction

    function void check_result(logic [2:0] st, logic [31:0] crc_v, logic [23:0] size_v);
        file_summary_t want;
        if (summary_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: status %0d crc %h size %0d", st, crc_v, size_v);
            return;
        end
        want = summary_q.pop_front();
        if (st !== want.status || crc_v !== want.crc || size_v !== want.size) begin
            errors++;
            if (errors <= 10) begin
                $display("result %0d mismatch: expected status %0d crc %h size %0d",
                         checked, want.status, want.crc, want.size);
                $display("result %0d mismatch:      got status %0d crc %h size %0d",
                         checked, st, crc_v, size_v);
            end
        end
        checked++;
    endfunction

    function int pending();
        return summary_q.size();
    endfunction
endclass

module lzss_decode_crc32_unit_tb;

    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 40;
    localparam int RANDOM_ITEMS = 1800;

    // bit 8 marks the final byte of a file
    localparam logic [8:0] DIRECTED_BYTES [30] = '{
        9'h110,
        9'h1A7,
        9'h010, 9'h000, 9'h000, 9'h100,
        9'h010, 9'h002, 9'h000, 9'h000, 9'h080, 9'h0FF, 9'h1FF,
        9'h010, 9'h003, 9'h000, 9'h000, 9'h040, 9'h0A5, 9'h0F0, 9'h100,
        9'h010, 9'h004, 9'h000, 9'h000, 9'h040, 9'h0A5, 9'h000, 9'h000, 9'h1EE
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        s_final_byte;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [31:0] m_crc_value;
    logic [23:0] m_out_size;

    lz_file_tracker files;
    logic [7:0]     file_q[$];
    bit             tx_calm;
    bit             rx_calm;
    int             idle_cycles = 0;

    lzss_decode_crc32_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_final_byte (s_final_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_crc_value  (m_crc_value),
        .m_out_size   (m_out_size)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] value, input logic last);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_in_byte    <= value;
        s_final_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        files.note_request(value, last);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (files.pending() != 0) @(posedge aclk);
    endtask

    // Well-formed stream decoding to exactly out_len bytes.
    function automatic void build_stream(logic [23:0] out_len, int unsigned ref_pct);
        int unsigned made;
        int unsigned room;
        int unsigned span;
        int unsigned ref_dist;
        int unsigned run;
        int unsigned slot;
        logic [7:0]  flag_byte;
        logic [11:0] dist_m1;
        logic [3:0]  run_m3;
        logic [7:0]  group[$];
        file_q.delete();
        file_q.push_back(lzdc_pkg::TYPE_ID);
        file_q.push_back(out_len[7:0]);
        file_q.push_back(out_len[15:8]);
        file_q.push_back(out_len[23:16]);
        made = 0;
        while (made < out_len) begin
            flag_byte = 8'($urandom_range(0, 255));
            group.delete();
            for (slot = 0; slot < 8 && made < out_len; slot++) begin
                room = out_len - made;
                if (made > 0 && room >= 3 && $urandom_range(1, 100) <= ref_pct) begin
                    span = (made > lzdc_pkg::WINDOW_DEPTH) ? lzdc_pkg::WINDOW_DEPTH : made;
                    case ($urandom_range(0, 3))
                        0: ref_dist = span;
                        1: ref_dist = 1;
                        default: ref_dist = $urandom_range(1, span);
                    endcase
                    if (room >= 18 && $urandom_range(0, 1) == 0) begin
                        run = 18;
                    end else begin
                        run = $urandom_range(3, (room > 18) ? 18 : room);
                    end
                    dist_m1 = 12'(ref_dist - 1);
                    run_m3 = 4'(run - 3);
                    flag_byte[7 - slot] = 1'b1;
                    group.push_back({run_m3, dist_m1[11:8]});
                    group.push_back(dist_m1[7:0]);
                    made += run;
                end else begin
                    flag_byte[7 - slot] = 1'b0;
                    group.push_back(8'($urandom_range(0, 255)));
                    made++;
                end
            end
            file_q.push_back(flag_byte);
            foreach (group[g]) file_q.push_back(group[g]);
        end
    endfunction

    initial begin
        m_ready = 1'b0;
        rx_calm = 1'b0;
        @(posedge aresetn);
        forever begin
            int unsigned gap;
            if ($urandom_range(0, 5) == 0) rx_calm = ~rx_calm;
            gap = rx_calm ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            files.check_result(m_status, m_crc_value, m_out_size);
        end
    end

    initial begin
        int unsigned kind;
        int unsigned cut;
        int unsigned pos;
        int unsigned n;
        bit          big_done;
        files = new();
        big_done = 1'b0;
        tx_calm = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_in_byte = 8'h00;
        s_final_byte = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED_BYTES[i]) push_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
        drain_results();

        while (files.live_requests < RANDOM_ITEMS + 30) begin
            kind = $urandom_range(0, 99);
            tx_calm = ($urandom_range(0, 3) == 0);
            if (!big_done && files.live_requests > 600) begin
                // one long file so references reach the full window and wrap it
                build_stream(24'($urandom_range(4097, 4400)), 90);
                big_done = 1'b1;
            end else if (kind < 85) begin
                if ($urandom_range(0, 7) == 0) begin
                    build_stream(24'($urandom_range(49, 400)), 50);
                end else begin
                    build_stream(24'($urandom_range(1, 48)), 50);
                end
                if (kind < 55) begin
                    if ($urandom_range(0, 3) == 0) begin
                        repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom_range(0, 255)));
                    end
                end else if (kind < 70) begin
                    cut = $urandom_range(0, file_q.size() - 2);
                    file_q = file_q[0:cut];
                end else begin
                    pos = $urandom_range(0, file_q.size() - 1);
                    file_q[pos] = file_q[pos] ^ 8'($urandom_range(1, 255));
                end
            end else begin
                file_q.delete();
                n = $urandom_range(1, 10);
                repeat (n) file_q.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 0) file_q[0] = lzdc_pkg::TYPE_ID;
                if (n >= 4 && $urandom_range(0, 4) == 0) begin
                    file_q[0] = lzdc_pkg::TYPE_ID;
                    file_q[1] = 8'h00;
                    file_q[2] = 8'h00;
                    file_q[3] = 8'h00;
                end
            end
            foreach (file_q[i]) push_byte(file_q[i], i == file_q.size() - 1);
            if ($urandom_range(0, 11) == 0) drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (files.errors == 0 && files.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
